[hdl/rfa_pkg.sv]
// ----------------------------------------------------------------------------
// rfa_pkg
// shared types and constants of the register file alu
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int DATA_W = 32;   // width of one register
    localparam int IDX_W  = 5;    // width of a register index field

    // operation codes
    typedef enum logic [3:0] {
        FN_MOV  = 4'd0,
        FN_XCHG = 4'd1,
        FN_INC  = 4'd2,
        FN_DEC  = 4'd3,
        FN_NOT  = 4'd4,
        FN_AND  = 4'd5,
        FN_OR   = 4'd6,
        FN_XOR  = 4'd7,
        FN_ADD  = 4'd8,
        FN_SUB  = 4'd9,
        FN_MUL  = 4'd10,
        FN_DIV  = 4'd11,
        FN_REM  = 4'd12,
        FN_NEG  = 4'd13,
        FN_MAX  = 4'd14,
        FN_MIN  = 4'd15
    } t_func;

    // result status codes
    localparam logic ST_DONE     = 1'b0;
    localparam logic ST_DIV_ZERO = 1'b1;

    // control from the sequencer to the serial unit
    typedef struct packed {
        logic  start;
        t_func func;
    } t_alu_ctl;

endpackage

[hdl/rfa_regfile.sv]
// ----------------------------------------------------------------------------
// rfa_regfile
// register storage: one write port, two registered read ports, valid bits
// so that entries read as zero after reset
// ----------------------------------------------------------------------------
module rfa_regfile #(
    parameter int REG_COUNT = 32,
    parameter int AW        = 5
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_we,
    input  logic [AW-1:0]              i_waddr,
    input  logic [rfa_pkg::DATA_W-1:0] i_wdata,
    input  logic [AW-1:0]              i_raddr_a,
    input  logic [AW-1:0]              i_raddr_b,
    output logic [rfa_pkg::DATA_W-1:0] o_rdata_a,
    output logic [rfa_pkg::DATA_W-1:0] o_rdata_b
);

    logic [rfa_pkg::DATA_W-1:0] r_mem [REG_COUNT];
    logic [REG_COUNT-1:0]       r_vld;
    logic [rfa_pkg::DATA_W-1:0] r_rd_a;
    logic [rfa_pkg::DATA_W-1:0] r_rd_b;

    // valid bits, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_we) begin
            r_vld[i_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd_a <= r_vld[i_raddr_a] ? r_mem[i_raddr_a] : '0;
        r_rd_b <= r_vld[i_raddr_b] ? r_mem[i_raddr_b] : '0;
    end

    assign o_rdata_a = r_rd_a;
    assign o_rdata_b = r_rd_b;

endmodule

[hdl/rfa_serial_alu.sv]
// ----------------------------------------------------------------------------
// rfa_serial_alu
// bit-serial alu with prepare and finish states for logic, add and compare,
// shift-add multiply and restoring divide, computed one bit per cycle
// ----------------------------------------------------------------------------
module rfa_serial_alu (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  rfa_pkg::t_alu_ctl          i_ctl,
    input  logic [rfa_pkg::DATA_W-1:0] i_a,
    input  logic [rfa_pkg::DATA_W-1:0] i_b,
    output logic                       o_done,
    output logic [rfa_pkg::DATA_W-1:0] o_result
);

    localparam int W      = rfa_pkg::DATA_W;
    localparam int STEP_W = $clog2(W);

    typedef enum logic [1:0] {
        S_IDLE,
        S_PREP,
        S_RUN,
        S_FIX
    } t_state;

    t_state          r_state;
    rfa_pkg::t_func  r_func;
    logic [W-1:0]    r_a;      // rotates, back in place after the run
    logic [W-1:0]    r_b;
    logic [W-1:0]    r_m;      // multiplicand or divisor magnitude
    logic [W-1:0]    r_acc;    // product or remainder
    logic [W-1:0]    r_sh;     // serial result or quotient
    logic            r_c;
    logic            r_lt;
    logic [STEP_W-1:0] r_cnt;
    logic            r_done;
    logic [W-1:0]    r_result;

    logic            a_bit;
    logic            b_bit;
    logic            x_bit;
    logic            y_bit;
    logic            sum_bit;
    logic            n_c;
    logic            ser_bit;
    logic            n_lt;
    logic            is_div;
    logic            last_step;
    logic [W-1:0]    n_prod;
    logic [W:0]      trial;
    logic [W-1:0]    mag_a;
    logic [W-1:0]    mag_b;
    logic [W-1:0]    fix_val;

    assign a_bit     = r_a[0];
    assign b_bit     = r_b[0];
    assign last_step = (r_cnt == STEP_W'(W - 1));
    assign is_div    = (r_func == rfa_pkg::FN_DIV) || (r_func == rfa_pkg::FN_REM);

    // adder operands of the add family
    always_comb begin
        x_bit = a_bit;
        y_bit = b_bit;
        case (r_func)
            rfa_pkg::FN_INC: y_bit = 1'b0;
            rfa_pkg::FN_DEC: y_bit = 1'b1;
            rfa_pkg::FN_SUB: y_bit = ~b_bit;
            rfa_pkg::FN_NEG: begin
                x_bit = 1'b0;
                y_bit = ~a_bit;
            end
            default: ;
        endcase
    end

    assign sum_bit = x_bit ^ y_bit ^ r_c;
    assign n_c     = (x_bit & y_bit) | (r_c & (x_bit ^ y_bit));

    always_comb begin
        case (r_func) inside
            rfa_pkg::FN_MOV: ser_bit = b_bit;
            rfa_pkg::FN_NOT: ser_bit = ~a_bit;
            rfa_pkg::FN_AND: ser_bit = a_bit & b_bit;
            rfa_pkg::FN_OR:  ser_bit = a_bit | b_bit;
            rfa_pkg::FN_XOR: ser_bit = a_bit ^ b_bit;
            rfa_pkg::FN_INC, rfa_pkg::FN_DEC, rfa_pkg::FN_ADD,
            rfa_pkg::FN_SUB, rfa_pkg::FN_NEG: ser_bit = sum_bit;
            default: ser_bit = 1'b0;
        endcase
    end

    // signed a < b, lsb first; the sign bit flips the sense
    always_comb begin
        if (last_step) begin
            n_lt = (a_bit & ~b_bit) | (~(a_bit ^ b_bit) & r_lt);
        end else begin
            n_lt = (~a_bit & b_bit) | (~(a_bit ^ b_bit) & r_lt);
        end
    end

    assign n_prod = r_acc + (b_bit ? r_m : '0);
    assign trial  = {r_acc, r_sh[W-1]} - {1'b0, r_m};
    assign mag_a  = r_a[W-1] ? (W'(0) - r_a) : r_a;
    assign mag_b  = r_b[W-1] ? (W'(0) - r_b) : r_b;

    always_comb begin
        case (r_func)
            rfa_pkg::FN_MUL: fix_val = r_acc;
            rfa_pkg::FN_DIV: fix_val = (r_a[W-1] ^ r_b[W-1]) ? (W'(0) - r_sh) : r_sh;
            rfa_pkg::FN_REM: fix_val = r_a[W-1] ? (W'(0) - r_acc) : r_acc;
            rfa_pkg::FN_MAX: fix_val = r_lt ? r_b : r_a;
            rfa_pkg::FN_MIN: fix_val = r_lt ? r_a : r_b;
            default:         fix_val = r_sh;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == S_FIX);
            unique case (r_state)
                S_IDLE: begin
                    if (i_ctl.start) begin
                        r_func  <= i_ctl.func;
                        r_a     <= i_a;
                        r_b     <= i_b;
                        r_state <= S_PREP;
                    end
                end
                S_PREP: begin
                    r_acc <= '0;
                    r_cnt <= '0;
                    r_lt  <= 1'b0;
                    r_c   <= (r_func == rfa_pkg::FN_INC) || (r_func == rfa_pkg::FN_SUB)
                             || (r_func == rfa_pkg::FN_NEG);
                    if (is_div) begin
                        r_sh <= mag_a;
                        r_m  <= mag_b;
                    end else begin
                        r_m <= r_a;
                    end
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    r_a   <= {r_a[0], r_a[W-1:1]};
                    r_b   <= {r_b[0], r_b[W-1:1]};
                    r_c   <= n_c;
                    r_lt  <= n_lt;
                    r_cnt <= r_cnt + 1'b1;
                    if (is_div) begin
                        if (!trial[W]) begin
                            r_acc <= trial[W-1:0];
                        end else begin
                            r_acc <= {r_acc[W-2:0], r_sh[W-1]};
                        end
                        r_sh <= {r_sh[W-2:0], ~trial[W]};
                    end else begin
                        r_acc <= n_prod;
                        r_m   <= {r_m[W-2:0], 1'b0};
                        r_sh  <= {ser_bit, r_sh[W-1:1]};
                    end
                    if (last_step) begin
                        r_state <= S_FIX;
                    end
                end
                S_FIX: begin
                    r_result <= fix_val;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

[hdl/register_file_alu.sv]
// ----------------------------------------------------------------------------
// register_file_alu
// file of signed 32-bit registers with a bit-serial alu, one operation per item
// ----------------------------------------------------------------------------
//
//  channel  dir  signals                      payload
//  -------  ---  ---------------------------  ------------------------------------
//  s        in   i_s_tvalid/o_s_tready         tdata: dest_index, src_index, immediate
//                                              tuser: func, src_is_immediate
//  m        out  o_m_tvalid/i_m_tready         tdata: dest_value, other_value
//                                              tuser: status
//
//  one item at a time: index reduction (REG_COUNT subtracted from any index not
//  below it, one subtract per step), read and load, serial alu (prepare, one bit
//  step per data bit, finish), hand-back, output load; exchange goes from load via
//  the exchange state to output load, division by zero from load to output load
//  reset clears all control and the register valid bits at once, no clearing pass
//  a stalled result waits in the output register; the next item is taken meanwhile
//
module register_file_alu #(
    parameter int REG_COUNT = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,   // dest_index[4:0], src_index[9:5], immediate[41:10], zero
    input  logic [4:0]  i_s_tuser,   // func[3:0], src_is_immediate[4]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [63:0] o_m_tdata,   // dest_value[31:0], other_value[63:32]
    output logic [0:0]  o_m_tuser    // status[0]
);

    localparam int W     = rfa_pkg::DATA_W;
    localparam int IW    = rfa_pkg::IDX_W;
    localparam int AW    = $clog2(REG_COUNT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_REDUCE,
        S_READ,
        S_LOAD,
        S_XCHG,
        S_BUSY,
        S_OUT
    } t_state;

    t_state          r_state;
    rfa_pkg::t_func  r_func;
    logic [IW-1:0]   r_d;
    logic [IW-1:0]   r_s;
    logic            r_use_imm;
    logic [W-1:0]    r_imm;
    logic [W-1:0]    r_cur;       // destination before the operation
    logic            r_status;
    logic [W-1:0]    r_res;
    logic [W-1:0]    r_other;
    logic            r_ovalid;
    logic [W-1:0]    r_odest;
    logic [W-1:0]    r_oother;
    logic            r_ostatus;

    // register file and alu hookup
    logic            rf_we;
    logic [AW-1:0]   rf_waddr;
    logic [W-1:0]    rf_wdata;
    logic [W-1:0]    rd_a;
    logic [W-1:0]    rd_b;
    logic [W-1:0]    src_val;
    logic            div_zero;
    rfa_pkg::t_alu_ctl alu_ctl;
    logic            alu_done;
    logic [W-1:0]    alu_res;
    logic            out_load;

    rfa_regfile #(
        .REG_COUNT (REG_COUNT),
        .AW        (AW)
    ) u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_we      (rf_we),
        .i_waddr   (rf_waddr),
        .i_wdata   (rf_wdata),
        .i_raddr_a (AW'(r_d)),
        .i_raddr_b (AW'(r_s)),
        .o_rdata_a (rd_a),
        .o_rdata_b (rd_b)
    );

    rfa_serial_alu u_alu (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (alu_ctl),
        .i_a      (rd_a),
        .i_b      (src_val),
        .o_done   (alu_done),
        .o_result (alu_res)
    );

    // operand selection at load time
    assign src_val  = r_use_imm ? r_imm : rd_b;
    assign div_zero = ((r_func == rfa_pkg::FN_DIV) || (r_func == rfa_pkg::FN_REM))
                      && (src_val == '0);

    // output register takes a new item when empty or being emptied
    assign out_load = (r_state == S_OUT) && (!r_ovalid || i_m_tready);

    always_comb begin
        alu_ctl.func  = r_func;
        alu_ctl.start = (r_state == S_LOAD) && (r_func != rfa_pkg::FN_XCHG) && !div_zero;
    end

    // register writes: exchange writes the destination in the load state and the source in the exchange state
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = AW'(r_d);
        rf_wdata = alu_res;
        case (r_state)
            S_LOAD: begin
                if (r_func == rfa_pkg::FN_XCHG) begin
                    rf_we    = 1'b1;
                    rf_wdata = rd_b;
                end
            end
            S_XCHG: begin
                rf_we    = 1'b1;
                rf_waddr = AW'(r_s);
                rf_wdata = r_cur;
            end
            S_BUSY: rf_we = alu_done;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_s_tvalid) begin
                        r_func    <= rfa_pkg::t_func'(i_s_tuser[3:0]);
                        r_use_imm <= i_s_tuser[4];
                        r_d       <= i_s_tdata[4:0];
                        r_s       <= i_s_tdata[9:5];
                        r_imm     <= i_s_tdata[41:10];
                        r_state   <= S_REDUCE;
                    end
                end
                S_REDUCE: begin
                    // indexes wrap modulo the register count
                    if (int'(r_d) >= REG_COUNT) begin
                        r_d <= r_d - IW'(REG_COUNT);
                    end else if (int'(r_s) >= REG_COUNT) begin
                        r_s <= r_s - IW'(REG_COUNT);
                    end else begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    r_cur <= rd_a;
                    if (r_func == rfa_pkg::FN_XCHG) begin
                        r_status <= rfa_pkg::ST_DONE;
                        r_res    <= rd_b;
                        r_other  <= rd_a;
                        r_state  <= S_XCHG;
                    end else if (div_zero) begin
                        // destination left as is
                        r_status <= rfa_pkg::ST_DIV_ZERO;
                        r_res    <= rd_a;
                        r_other  <= src_val;
                        r_state  <= S_OUT;
                    end else begin
                        r_status <= rfa_pkg::ST_DONE;
                        r_other  <= src_val;
                        r_state  <= S_BUSY;
                    end
                end
                S_XCHG: begin
                    r_state <= S_OUT;
                end
                S_BUSY: begin
                    if (alu_done) begin
                        r_res   <= alu_res;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_odest   <= r_res;
                        r_oother  <= r_other;
                        r_ostatus <= r_status;
                        r_state   <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_s_tready   = (r_state == S_IDLE);
    assign o_m_tvalid   = r_ovalid;
    assign o_m_tdata    = {r_oother, r_odest};
    assign o_m_tuser[0] = r_ostatus;

endmodule
